@@ src/hmte_pkg.sv @@
package hmte_pkg;

    // Page window length: the content opening is matched in one look.
    localparam int LOOKAHEAD = 25;
    localparam int TAG_WIN   = 4;

    localparam int PFILL_W = $clog2(LOOKAHEAD + 1);
    localparam int PIDX_W  = $clog2(LOOKAHEAD);
    localparam int TFILL_W = $clog2(TAG_WIN + 1);
    localparam int TIDX_W  = $clog2(TAG_WIN);

    typedef logic [7:0] byte_t;

    // Element k of a window is the k-th oldest byte.
    typedef logic [LOOKAHEAD-1:0][7:0] page_win_t;
    typedef logic [TAG_WIN-1:0][7:0]   tag_win_t;

    typedef struct packed {
        byte_t data;
        logic  empty;
        logic  last;
    } res_t;

    localparam int OPEN_LEN   = 25;
    localparam int DOPEN_LEN  = 4;
    localparam int DCLOSE_LEN = 5;
    localparam int H2_LEN     = 4;

    localparam byte_t CH_LT  = 8'h3C;
    localparam byte_t CH_GT  = 8'h3E;
    localparam byte_t CH_LBR = 8'h5B;
    localparam byte_t CH_RBR = 8'h5D;
    localparam byte_t CH_NL  = 8'h0A;

    // A string literal holds its first character in the highest byte; this
    // turns it around into window order.
    function automatic page_win_t str_to_win(input logic [8*LOOKAHEAD-1:0] s, input int len);
        page_win_t w;
        w = '0;
        for (int k = 0; k < LOOKAHEAD; k++) begin
            if (k < len) begin
                w[k] = s[8*(len-1-k) +: 8];
            end
        end
        return w;
    endfunction

    localparam page_win_t OPEN_PAT   = str_to_win("<div id=\"mw-content-text\"", OPEN_LEN);
    localparam page_win_t DOPEN_PAT  = str_to_win("<div", DOPEN_LEN);
    localparam page_win_t DCLOSE_PAT = str_to_win("</div", DCLOSE_LEN);
    localparam page_win_t H2_FULL    = str_to_win("<h2>", H2_LEN);
    localparam tag_win_t  H2_PAT     = H2_FULL[TAG_WIN-1:0];

endpackage

@@ src/hmte_skid.sv @@
module hmte_skid
    import hmte_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_item
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] count_reg, count_next;
    res_t       head_reg, head_next;
    res_t       tail_reg, tail_next;
    logic       push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != CNT_EMPTY);
    assign out_item  = head_reg;

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10: begin
                if (count_reg == CNT_EMPTY) begin
                    head_next = in_item;
                end else begin
                    tail_next = in_item;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                if (count_reg == CNT_ONE) begin
                    head_next = in_item;
                end else begin
                    head_next = tail_reg;
                    tail_next = in_item;
                end
            end
            2'b00: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_EMPTY;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

@@ src/html_main_text_extractor_unit.sv @@
// Channel  Ports                        Fields (lowest bit first)
// input    s_tvalid/s_tready/s_tdata    s_tdata: in_byte; s_tlast: in_last
// result   m_tvalid/m_tready/m_tdata    m_tdata: out_byte; m_tuser: out_empty;
//                                       m_tlast: out_last
//
// While a page runs and the result buffer has room, one byte is taken per cycle;
// the 25-byte window compare, depth update, tag and bracket filters all sit
// between the state registers and a two-entry result buffer, so s_tready depends
// on registers only. When the content div closes, the tag window drains before
// input is taken again. The last byte of a page drains the page window, one step
// per cycle while the buffer has room, then the tag window; the end mark follows.
// aresetn is synchronous; it clears control state, the byte windows are not
// cleared. A stalled result side fills the buffer and then holds s_tready low.
module html_main_text_extractor_unit
    import hmte_pkg::*;
#(
    parameter int DEPTH_BITS = 16
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tuser,   // out_empty
    output logic       m_tlast
);

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_PFLUSH = 2'd1;
    localparam logic [1:0] ST_TFLUSH = 2'd2;
    localparam logic [1:0] ST_END    = 2'd3;

    localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = {DEPTH_BITS{1'b1}};

    function automatic logic page_match(page_win_t w, logic [PFILL_W-1:0] avail,
                                        page_win_t pat, int plen);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < LOOKAHEAD; k++) begin
            if (k < plen && k < int'(avail) && w[k] != pat[k]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic tag_match(tag_win_t w, logic [TFILL_W-1:0] avail);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < TAG_WIN; k++) begin
            if (k < int'(avail) && w[k] != H2_PAT[k]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [1:0]            state_reg, state_next;
    logic                  last_mode_reg, last_mode_next;
    page_win_t             pw_reg, pw_next, pw_work;
    logic [PFILL_W-1:0]    pfill_reg, pfill_next, pfill_work;
    logic                  inside_content_reg, inside_content_next;
    logic                  content_done_reg, content_done_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next, depth_inc, depth_dec;
    tag_win_t              tw_reg, tw_next, tw_work;
    logic [TFILL_W-1:0]    tfill_reg, tfill_next, tfill_work;
    logic                  inside_tag_reg, inside_tag_next;
    logic                  inside_bracket_reg, inside_bracket_next;
    logic                  hold_valid_reg, hold_valid_next;
    byte_t                 hold_byte_reg, hold_byte_next;

    logic  s_accept, step_en, to_hold;
    logic  do_page, m_open, m_dopen, m_dclose, ic, close, tpush;
    logic  do_tag, it, ib, h2, bcall, gen_valid;
    byte_t c0, bin;

    logic  skid_in_valid, skid_in_ready, skid_out_valid;
    res_t  skid_in_item, skid_out_item;

    assign s_tready = (state_reg == ST_RUN) && skid_in_ready;
    assign s_accept = s_tvalid && s_tready;
    assign step_en  = (state_reg == ST_RUN) ? s_accept : skid_in_ready;
    assign to_hold  = last_mode_reg || (s_accept && s_tlast);

    always_comb begin
        // Page window source: a new byte in RUN, the stored window in PFLUSH.
        pw_work    = pw_reg;
        pfill_work = pfill_reg;
        do_page    = 1'b0;
        if (state_reg == ST_RUN) begin
            if (s_accept && !content_done_reg && pfill_reg < PFILL_W'(LOOKAHEAD)) begin
                pw_work[pfill_reg[PIDX_W-1:0]] = s_tdata;
                pfill_work = pfill_reg + PFILL_W'(1);
                do_page    = (pfill_reg == PFILL_W'(LOOKAHEAD - 1));
            end
        end else if (state_reg == ST_PFLUSH) begin
            do_page = skid_in_ready && !content_done_reg && pfill_reg != '0;
        end

        m_open   = page_match(pw_work, pfill_work, OPEN_PAT, OPEN_LEN);
        m_dopen  = page_match(pw_work, pfill_work, DOPEN_PAT, DOPEN_LEN);
        m_dclose = page_match(pw_work, pfill_work, DCLOSE_PAT, DCLOSE_LEN);
        ic       = inside_content_reg || m_open;
        depth_inc = (m_dopen && depth_reg != DEPTH_TOP) ?
                    depth_reg + DEPTH_BITS'(1) : depth_reg;
        depth_dec = (m_dclose && depth_inc != '0) ?
                    depth_inc - DEPTH_BITS'(1) : depth_inc;

        pw_next             = pw_work;
        pfill_next          = pfill_work;
        inside_content_next = inside_content_reg;
        content_done_next   = content_done_reg;
        depth_next          = depth_reg;
        close               = 1'b0;
        tpush               = 1'b0;
        if (do_page) begin
            inside_content_next = ic;
            if (ic) begin
                depth_next = depth_dec;
                if (depth_dec == '0) begin
                    close             = 1'b1;
                    content_done_next = 1'b1;
                end else begin
                    tpush = 1'b1;
                end
            end
            // The window keeps its place once the content has closed.
            if (!close) begin
                for (int k = 0; k < LOOKAHEAD - 1; k++) begin
                    pw_next[k] = pw_work[k+1];
                end
                pfill_next = pfill_work - PFILL_W'(1);
            end
        end

        // Tag window source: the byte leaving the page window, or a drain step.
        tw_work    = tw_reg;
        tfill_work = tfill_reg;
        do_tag     = 1'b0;
        if (tpush) begin
            tw_work[tfill_reg[TIDX_W-1:0]] = pw_work[0];
            tfill_work = tfill_reg + TFILL_W'(1);
            do_tag     = (tfill_reg == TFILL_W'(TAG_WIN - 1));
        end else if (state_reg == ST_TFLUSH) begin
            do_tag = skid_in_ready && tfill_reg != '0;
        end

        c0    = tw_work[0];
        it    = inside_tag_reg || (c0 == CH_LT);
        h2    = it && tag_match(tw_work, tfill_work);
        bin   = h2 ? CH_NL : c0;
        bcall = h2 || !it;
        ib    = inside_bracket_reg || (bin == CH_LBR);

        tw_next             = tw_work;
        tfill_next          = tfill_work;
        inside_tag_next     = inside_tag_reg;
        inside_bracket_next = inside_bracket_reg;
        gen_valid           = 1'b0;
        if (do_tag) begin
            inside_tag_next = it && (c0 != CH_GT);
            if (bcall) begin
                inside_bracket_next = ib && (bin != CH_RBR);
                gen_valid           = !ib;
            end
            for (int k = 0; k < TAG_WIN - 1; k++) begin
                tw_next[k] = tw_work[k+1];
            end
            tfill_next = tfill_work - TFILL_W'(1);
        end

        state_next     = state_reg;
        last_mode_next = last_mode_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (s_tlast) begin
                    last_mode_next = 1'b1;
                    state_next     = content_done_next ? ST_TFLUSH : ST_PFLUSH;
                end else if (close) begin
                    state_next = ST_TFLUSH;
                end
            end
            ST_PFLUSH: begin
                if (!do_page) begin
                    state_next = ST_TFLUSH;
                end
            end
            ST_TFLUSH: begin
                if (!do_tag) begin
                    state_next = last_mode_reg ? ST_END : ST_RUN;
                end
            end
            ST_END: begin
                state_next = ST_RUN;
            end
        endcase

        // On the last page the newest result is held back, so that the end
        // mark can be set on it once the drain is over.
        skid_in_valid   = 1'b0;
        skid_in_item    = '{data: bin, empty: 1'b0, last: 1'b0};
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        if (state_reg == ST_END) begin
            skid_in_valid   = step_en;
            skid_in_item    = hold_valid_reg ?
                              '{data: hold_byte_reg, empty: 1'b0, last: 1'b1} :
                              '{data: 8'h00, empty: 1'b1, last: 1'b1};
            hold_valid_next = 1'b0;
        end else if (gen_valid) begin
            if (to_hold) begin
                skid_in_valid   = hold_valid_reg;
                skid_in_item    = '{data: hold_byte_reg, empty: 1'b0, last: 1'b0};
                hold_valid_next = 1'b1;
                hold_byte_next  = bin;
            end else begin
                skid_in_valid = 1'b1;
            end
        end

        if (state_reg == ST_END) begin
            pfill_next          = '0;
            inside_content_next = 1'b0;
            content_done_next   = 1'b0;
            depth_next          = '0;
            tfill_next          = '0;
            inside_tag_next     = 1'b0;
            inside_bracket_next = 1'b0;
            last_mode_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_RUN;
            last_mode_reg      <= 1'b0;
            pfill_reg          <= '0;
            inside_content_reg <= 1'b0;
            content_done_reg   <= 1'b0;
            depth_reg          <= '0;
            tfill_reg          <= '0;
            inside_tag_reg     <= 1'b0;
            inside_bracket_reg <= 1'b0;
            hold_valid_reg     <= 1'b0;
        end else if (step_en) begin
            state_reg          <= state_next;
            last_mode_reg      <= last_mode_next;
            pfill_reg          <= pfill_next;
            inside_content_reg <= inside_content_next;
            content_done_reg   <= content_done_next;
            depth_reg          <= depth_next;
            tfill_reg          <= tfill_next;
            inside_tag_reg     <= inside_tag_next;
            inside_bracket_reg <= inside_bracket_next;
            hold_valid_reg     <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            pw_reg        <= pw_next;
            tw_reg        <= tw_next;
            hold_byte_reg <= hold_byte_next;
        end
    end

    hmte_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (skid_in_valid),
        .in_ready  (skid_in_ready),
        .in_item   (skid_in_item),
        .out_valid (skid_out_valid),
        .out_ready (m_tready),
        .out_item  (skid_out_item)
    );

    assign m_tvalid = skid_out_valid;
    assign m_tdata  = skid_out_item.data;
    assign m_tuser  = skid_out_item.empty;
    assign m_tlast  = skid_out_item.last;

`ifndef SYNTHESIS
    a_hold_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> last_mode_reg)
        else $error("held result outside the last-page drain");

    a_tag_window_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (tfill_reg < TFILL_W'(TAG_WIN)))
        else $error("tag window full while taking input");

    a_done_needs_content: assert property (@(posedge aclk) disable iff (!aresetn)
        content_done_reg |-> inside_content_reg)
        else $error("content closed without having opened");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_END && skid_in_ready) |=>
        (state_reg == ST_RUN && pfill_reg == '0 && tfill_reg == '0 && !hold_valid_reg))
        else $error("page end did not return to the idle state");
`endif

endmodule

@@ tb/sv/html_main_text_extractor_unit_test.sv @@
module html_main_text_extractor_unit_test
    import hmte_pkg::*;
();

    localparam int DEPTH_BITS   = 4;
    localparam int MAX_RESULTS  = 30;
    localparam int RANDOM_BYTES = 160;
    localparam int QUIET_TAIL   = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 200_000;

    typedef struct {
        string text;
        byte_t raw;
        int    reps;
        bit    ends;
        bit    mark_only;
    } seg_t;

    logic  aclk;
    logic  aresetn  = 1'b0;
    logic  s_tvalid = 1'b0;
    logic  s_tready;
    byte_t s_tdata  = '0;
    logic  s_tlast  = 1'b0;
    logic  m_tvalid;
    logic  m_tready = 1'b0;
    byte_t m_tdata;
    logic  m_tuser;
    logic  m_tlast;

    string open_text = "<div id=\"mw-content-text\"";

    // Predictor state.
    byte_t                 pg_win[LOOKAHEAD];
    int                    pg_fill;
    bit                    in_content;
    bit                    content_closed;
    logic [DEPTH_BITS-1:0] div_level;
    byte_t                 tg_win[TAG_WIN];
    int                    tg_fill;
    bit                    in_tag;
    bit                    in_bracket;
    res_t                  step_text[$];
    res_t                  text_due[$];

    seg_t   plan[$];
    bit     idle_on       = 1'b1;
    bit     long_hold     = 1'b0;
    bit     row_mark_only = 1'b0;
    int     error_count   = 0;
    longint cycles        = 0;

    html_main_text_extractor_unit #(
        .DEPTH_BITS(DEPTH_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_text_state();
        for (int k = 0; k < LOOKAHEAD; k++) pg_win[k] = '0;
        for (int k = 0; k < TAG_WIN; k++) tg_win[k] = '0;
        pg_fill        = 0;
        tg_fill        = 0;
        in_content     = 1'b0;
        content_closed = 1'b0;
        div_level      = '0;
        in_tag         = 1'b0;
        in_bracket     = 1'b0;
    endfunction

    // Near the end of a page only the bytes still held are compared.
    function automatic bit page_has(input string pat, input int avail);
        for (int k = 0; k < pat.len() && k < avail; k++) begin
            if (pg_win[k] != byte_t'(pat[k])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit tag_has_h2(input int avail);
        string h2;
        h2 = "<h2>";
        for (int k = 0; k < h2.len() && k < avail; k++) begin
            if (tg_win[k] != byte_t'(h2[k])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void bracket_filter(input byte_t c);
        if (c == CH_LBR) in_bracket = 1'b1;
        if (!in_bracket && step_text.size() < MAX_RESULTS) begin
            step_text.push_back('{data: c, empty: 1'b0, last: 1'b0});
        end
        if (c == CH_RBR) in_bracket = 1'b0;
    endfunction

    function automatic void tag_advance(input int avail);
        byte_t c;
        c = tg_win[0];
        if (c == CH_LT) in_tag = 1'b1;
        if (in_tag && tag_has_h2(avail)) bracket_filter(CH_NL);
        if (!in_tag) bracket_filter(c);
        if (c == CH_GT) in_tag = 1'b0;
        for (int k = 0; k < TAG_WIN - 1; k++) tg_win[k] = tg_win[k + 1];
        tg_fill--;
    endfunction

    function automatic void tag_take(input byte_t c);
        if (tg_fill < TAG_WIN) begin
            tg_win[tg_fill] = c;
            tg_fill++;
        end
        if (tg_fill == TAG_WIN) tag_advance(TAG_WIN);
    endfunction

    function automatic void tag_drain();
        while (tg_fill > 0) tag_advance(tg_fill);
    endfunction

    function automatic void page_advance(input int avail);
        byte_t c;
        c = pg_win[0];
        if (!in_content && page_has(open_text, avail)) in_content = 1'b1;
        if (in_content) begin
            if (page_has("<div", avail) && div_level != '1) div_level++;
            if (page_has("</div", avail) && div_level != '0) div_level--;
            // The byte that balances the divs is dropped and the window stays put.
            if (div_level == '0) begin
                content_closed = 1'b1;
                tag_drain();
                return;
            end
            tag_take(c);
        end
        for (int k = 0; k < LOOKAHEAD - 1; k++) pg_win[k] = pg_win[k + 1];
        pg_fill--;
    endfunction

    function automatic void extract_byte(input byte_t b, input bit is_last);
        step_text.delete();
        if (!content_closed) begin
            if (pg_fill < LOOKAHEAD) begin
                pg_win[pg_fill] = b;
                pg_fill++;
            end
            if (pg_fill == LOOKAHEAD) page_advance(LOOKAHEAD);
        end
        if (is_last) begin
            while (!content_closed && pg_fill > 0) page_advance(pg_fill);
            tag_drain();
            if (step_text.size() == 0) begin
                step_text.push_back('{data: 8'h00, empty: 1'b1, last: 1'b1});
            end else begin
                step_text[step_text.size() - 1].last = 1'b1;
            end
            clear_text_state();
        end
    endfunction

    function automatic void report_mismatch(input string what, input res_t want);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s: expected byte %02h empty %0b last %0b, got byte %02h empty %0b last %0b",
                     $time, what, want.data, want.empty, want.last, m_tdata, m_tuser, m_tlast);
        end
    endfunction

    // Requests are predicted before results are checked, both on the same edge.
    always @(posedge aclk) begin : text_check
        res_t want;
        if (aresetn === 1'b1 && s_tvalid === 1'b1 && s_tready === 1'b1) begin
            extract_byte(s_tdata, s_tlast);
            if (!row_mark_only) begin
                foreach (step_text[i]) text_due.push_back(step_text[i]);
            end else if (s_tlast) begin
                text_due.push_back('{data: 8'h00, empty: 1'b1, last: 1'b1});
            end
        end
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (text_due.size() == 0) begin
                want = '0;
                report_mismatch("result with none expected", want);
            end else begin
                want = text_due.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.empty || m_tlast !== want.last) begin
                    report_mismatch("result differs", want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : result_side
        int gap;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic put_byte(input byte_t b, input bit is_last, input bit mark, input bit may_idle);
        int gap;
        @(negedge aclk);
        if (may_idle && idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= b;
        s_tlast       <= is_last;
        row_mark_only <= mark;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
    endtask

    function automatic void plan_row(input string text, input byte_t raw, input int reps,
                                     input bit ends, input bit mark_only);
        plan.push_back('{text, raw, reps, ends, mark_only});
    endfunction

    function automatic void add_text(ref byte_t q[$], input string s);
        for (int k = 0; k < s.len(); k++) q.push_back(byte_t'(s[k]));
    endfunction

    function automatic void add_noise(ref byte_t q[$], input int n);
        for (int k = 0; k < n; k++) q.push_back(byte_t'($urandom_range(0, 255)));
    endfunction

    function automatic void make_page(ref byte_t q[$], input int tokens, input bit well_formed);
        int shape;
        int level;
        int cut;
        q.delete();
        case ($urandom_range(0, 3))
            0: ;
            1: add_noise(q, $urandom_range(1, 4));
            2: add_text(q, "<div>");
            default: add_text(q, "<p>x</p>");
        endcase
        shape = well_formed ? 2 : $urandom_range(0, 9);
        if (shape == 0) begin
            // The opening is cut short, so the content never starts before the end.
            cut = $urandom_range(1, LOOKAHEAD - 1);
            add_text(q, open_text.substr(0, cut - 1));
            if ($urandom_range(0, 1)) add_noise(q, $urandom_range(1, 20));
            return;
        end
        if (shape == 1) begin
            add_noise(q, $urandom_range(1, 40));
            return;
        end
        add_text(q, open_text);
        level = 1;
        repeat (tokens) begin
            case ($urandom_range(0, 11))
                0: add_text(q, " the ");
                1: add_text(q, "Main text.");
                2: add_text(q, "[12]");
                3: add_text(q, "<h2>");
                4: add_text(q, "</h2>");
                5: add_text(q, "<p class=\"x\">");
                6: add_text(q, "</p>");
                7: begin
                    add_text(q, "<div>");
                    level++;
                end
                8: if (level > 1) begin
                    add_text(q, "</div>");
                    level--;
                end
                9: add_noise(q, $urandom_range(1, 4));
                10: add_text(q, "a]b>c[d");
                default: add_text(q, "<h2 id=\"s\">Sec</h2>");
            endcase
        end
        if ($urandom_range(0, 4) != 0) begin
            repeat (level) add_text(q, "</div>");
            if ($urandom_range(0, 1)) add_text(q, "<p>after</p>");
        end else begin
            // The page stops inside the content, often partway through a tag.
            case ($urandom_range(0, 3))
                0: add_text(q, "<h");
                1: add_text(q, "</di");
                2: add_text(q, "<");
                default: ;
            endcase
        end
    endfunction

    initial begin : stimulus
        byte_t page[$];
        int    sent;
        int    pages;
        int    len;
        clear_text_state();

        // Lone bytes and a page without the content opening give only the end mark.
        plan_row("x", 8'h00, 1, 1, 1);
        plan_row("", 8'h00, 1, 1, 1);
        plan_row("", 8'hFF, 30, 1, 1);
        // An opening cut short by the end of the page still counts as found.
        plan_row(open_text.substr(0, 10), 8'h00, 1, 1, 0);
        // Text, brackets, an h2, a nested div, zero and all-ones bytes, then
        // bytes after the close that must be ignored.
        plan_row(open_text, 8'h00, 1, 0, 0);
        plan_row("A [1]b]>c<h2>T</h2>d", 8'h00, 1, 0, 0);
        plan_row("", 8'h00, 2, 0, 0);
        plan_row("", 8'hFF, 2, 0, 0);
        plan_row("<div>e</div>f", 8'h00, 1, 0, 0);
        plan_row("</div>gh<p>", 8'h00, 1, 1, 0);
        // The page ends inside the content on a partial h2.
        plan_row(open_text, 8'h00, 1, 0, 0);
        plan_row("k<h", 8'h00, 1, 1, 0);
        // Enough nested opens to pin the depth at its top, then one close.
        plan_row(open_text, 8'h00, 1, 0, 0);
        plan_row("<div", 8'h00, 16, 0, 0);
        plan_row("</div>", 8'h00, 1, 0, 0);
        plan_row("z[q]", 8'h00, 1, 1, 0);
        plan_row(open_text, 8'h00, 1, 1, 0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            len = (plan[i].text.len() == 0) ? 1 : plan[i].text.len();
            for (int n = 0; n < plan[i].reps; n++) begin
                for (int k = 0; k < len; k++) begin
                    put_byte((plan[i].text.len() == 0) ? plan[i].raw : byte_t'(plan[i].text[k]),
                             plan[i].ends && n == plan[i].reps - 1 && k == len - 1,
                             plan[i].mark_only, plan[i].reps < 100);
                end
            end
        end

        sent  = 0;
        pages = 0;
        while (sent < RANDOM_BYTES || pages < 2) begin
            make_page(page, (pages == 0) ? 12 : $urandom_range(2, 10), pages == 0);
            if (pages == 1) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (text_due.size() != 0) @(posedge aclk);
            end
            // A long result-side stall while this page keeps coming fills the block.
            if (pages == 0) long_hold = 1'b1;
            if (sent > RANDOM_BYTES - QUIET_TAIL) idle_on = 1'b0;
            foreach (page[i]) put_byte(page[i], i == page.size() - 1, 1'b0, 1'b1);
            sent += page.size();
            pages++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (text_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (error_count == 0 && text_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
